@@ src/lsct_pkg.sv @@
// Shared types, constants and character helpers for the line splitter / comment trimmer.
// Used by every module of the block except lsct_ram; depends on nothing.
package lsct_pkg;

  // Held whitespace store
  localparam int HOLD_DEPTH = 32;
  localparam int HOLD_AW    = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;
  localparam int HOLD_CW    = $clog2(HOLD_DEPTH + 1);
  localparam int WS_CODE_W  = 2;

  // Command queue between front and back
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam int LEN_W      = 17;
  localparam int MAXLEN_W   = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_PREPROCESS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN    = 1'd1;
  localparam logic [MAXLEN_W-1:0]  MAX_LEN_RESET  = 16'd4096;

  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_SP   = 8'h20;
  localparam logic [7:0] CH_TAB  = 8'h09;
  localparam logic [7:0] CH_VT   = 8'h0B;
  localparam logic [7:0] CH_FF   = 8'h0C;

  localparam logic [WS_CODE_W-1:0] WS_SP  = 2'd0;
  localparam logic [WS_CODE_W-1:0] WS_TAB = 2'd1;
  localparam logic [WS_CODE_W-1:0] WS_VT  = 2'd2;
  localparam logic [WS_CODE_W-1:0] WS_FF  = 2'd3;

  typedef enum logic [2:0] {
    CMD_CHAR,   // release held whitespace, then send the character
    CMD_PUSH,   // append a whitespace code to the held store
    CMD_CLEAR,  // discard held whitespace
    CMD_CLOSE,  // line end with flags, discard held whitespace
    CMD_EOD     // end-of-data marker
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t    op;
    logic [7:0] data;
    logic       too_long;
    logic       overflow;
  } cmd_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SP) || (c == CH_TAB) || (c == CH_VT) || (c == CH_FF);
  endfunction

  function automatic logic [WS_CODE_W-1:0] ws_code(input logic [7:0] c);
    logic [WS_CODE_W-1:0] code;
    case (c)
      CH_TAB:  code = WS_TAB;
      CH_VT:   code = WS_VT;
      CH_FF:   code = WS_FF;
      default: code = WS_SP;
    endcase
    return code;
  endfunction

  function automatic logic [7:0] ws_char(input logic [WS_CODE_W-1:0] code);
    logic [7:0] c;
    case (code)
      WS_SP:   c = CH_SP;
      WS_TAB:  c = CH_TAB;
      WS_VT:   c = CH_VT;
      WS_FF:   c = CH_FF;
      default: c = CH_SP;
    endcase
    return c;
  endfunction

endpackage

@@ src/lsct_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lsct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ src/lsct_cmd_fifo.sv @@
// Short command queue that decouples the classifying front from the output back.
// Depends on lsct_pkg (cmd_t, FIFO_DEPTH).
module lsct_cmd_fifo import lsct_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_data,
  output logic full,
  input  logic pop,
  output cmd_t pop_data,
  output logic empty
);

  cmd_t               slot_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r;
  logic [FIFO_AW-1:0] rd_ptr_r;
  logic [FIFO_AW:0]   count_r;

  logic do_push;
  logic do_pop;

  assign full     = (count_r == (FIFO_AW + 1)'(FIFO_DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + FIFO_AW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + FIFO_AW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + (FIFO_AW + 1)'(1);
        2'b01:   count_r <= count_r - (FIFO_AW + 1)'(1);
        default: count_r <= count_r;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (FIFO_AW + 1)'(FIFO_DEPTH))
    else $error("command queue count beyond depth");
`endif

endmodule

@@ src/lsct_front.sv @@
// Front end: configuration registers, byte classification and per-line trimming state.
// Turns each accepted beat into at most one queue command. Depends on lsct_pkg.
module lsct_front import lsct_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_byte,
  input  logic                  in_eos,
  output logic                  cmd_push,
  output cmd_t                  cmd_data,
  input  logic                  cmd_full
);

  logic                pre_en_r;
  logic [MAXLEN_W-1:0] max_len_r;

  logic [HOLD_CW-1:0]  held_r,     held_nxt;
  logic [LEN_W-1:0]    len_r,      len_nxt;
  logic                comment_r,  comment_nxt;
  logic                content_r,  content_nxt;
  logic                prev_sp_r,  prev_sp_nxt;
  logic                raw_seen_r, raw_seen_nxt;
  logic                len_err_r,  len_err_nxt;
  logic                ovf_r,      ovf_nxt;
  logic                done_r,     done_nxt;

  logic accept;
  logic cmd_vld;
  logic at_start;
  logic ws;

  assign in_ready = !cmd_full;
  assign accept   = in_valid && in_ready;
  assign cmd_push = accept && cmd_vld;
  assign at_start = (len_r == '0);
  assign ws       = is_ws(in_byte);

  always_comb begin
    held_nxt     = held_r;
    len_nxt      = len_r;
    comment_nxt  = comment_r;
    content_nxt  = content_r;
    prev_sp_nxt  = prev_sp_r;
    raw_seen_nxt = raw_seen_r;
    len_err_nxt  = len_err_r;
    ovf_nxt      = ovf_r;
    done_nxt     = done_r;
    cmd_vld      = 1'b0;
    cmd_data     = '{op: CMD_EOD, data: 8'd0, too_long: 1'b0, overflow: 1'b0};

    if (done_r) begin
      cmd_vld = 1'b1;
    end else if (in_eos || (in_byte == CH_LF)) begin
      cmd_vld = 1'b1;
      if (in_eos) begin
        done_nxt = 1'b1;
      end
      if (raw_seen_r || !in_eos) begin
        cmd_data.op       = CMD_CLOSE;
        cmd_data.too_long = len_err_r;
        cmd_data.overflow = ovf_r;
        held_nxt     = '0;
        len_nxt      = '0;
        comment_nxt  = 1'b0;
        content_nxt  = 1'b0;
        prev_sp_nxt  = 1'b0;
        raw_seen_nxt = 1'b0;
        len_err_nxt  = 1'b0;
        ovf_nxt      = 1'b0;
      end
    end else begin
      raw_seen_nxt = 1'b1;
      if (in_byte == CH_CR) begin
        // carriage returns vanish
      end else if (len_r >= LEN_W'(max_len_r)) begin
        len_err_nxt = 1'b1;
      end else begin
        len_nxt     = len_r + LEN_W'(1);
        prev_sp_nxt = ws;
        if (!pre_en_r) begin
          cmd_vld       = 1'b1;
          cmd_data.op   = CMD_CHAR;
          cmd_data.data = in_byte;
          held_nxt      = '0;
          if (!ws) begin
            content_nxt = 1'b1;
          end
        end else if (comment_r) begin
          // rest of the line is comment
        end else if ((in_byte == CH_HASH) && (at_start || prev_sp_r)) begin
          comment_nxt = 1'b1;
          held_nxt    = '0;
          cmd_vld     = 1'b1;
          cmd_data.op = CMD_CLEAR;
        end else if (ws) begin
          if (content_r) begin
            if (held_r < HOLD_CW'(HOLD_DEPTH)) begin
              held_nxt      = held_r + HOLD_CW'(1);
              cmd_vld       = 1'b1;
              cmd_data.op   = CMD_PUSH;
              cmd_data.data = {{(8 - WS_CODE_W){1'b0}}, ws_code(in_byte)};
            end else begin
              ovf_nxt = 1'b1;
            end
          end
        end else begin
          cmd_vld       = 1'b1;
          cmd_data.op   = CMD_CHAR;
          cmd_data.data = in_byte;
          held_nxt      = '0;
          content_nxt   = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_en_r   <= 1'b0;
      max_len_r  <= MAX_LEN_RESET;
      held_r     <= '0;
      len_r      <= '0;
      comment_r  <= 1'b0;
      content_r  <= 1'b0;
      prev_sp_r  <= 1'b0;
      raw_seen_r <= 1'b0;
      len_err_r  <= 1'b0;
      ovf_r      <= 1'b0;
      done_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_PREPROCESS: pre_en_r  <= cfg_wdata[0];
          CFG_MAX_LEN:    max_len_r <= cfg_wdata[MAXLEN_W-1:0];
          default:        ;
        endcase
      end
      if (accept) begin
        held_r     <= held_nxt;
        len_r      <= len_nxt;
        comment_r  <= comment_nxt;
        content_r  <= content_nxt;
        prev_sp_r  <= prev_sp_nxt;
        raw_seen_r <= raw_seen_nxt;
        len_err_r  <= len_err_nxt;
        ovf_r      <= ovf_nxt;
        done_r     <= done_nxt;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> done_r)
    else $error("stream done flag dropped without reset");

  a_held_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= HOLD_CW'(HOLD_DEPTH))
    else $error("held whitespace count beyond store depth");
`endif

endmodule

@@ src/lsct_back.sv @@
// Back end: executes queued commands, owns the held whitespace RAM and the output register.
// Depends on lsct_pkg and lsct_ram.
module lsct_back import lsct_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd_head,
  input  logic        cmd_empty,
  output logic        cmd_pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_char,
  output logic        out_char_valid,
  output logic        out_line_end,
  output logic        out_too_long,
  output logic        out_hold_ovf,
  output logic        out_eod
);

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_REL_RD,
    BK_REL_WR,
    BK_CHAR
  } bk_state_t;

  bk_state_t          state_r, state_nxt;
  logic [HOLD_CW-1:0] cnt_r,   cnt_nxt;
  logic [HOLD_AW-1:0] idx_r,   idx_nxt;
  logic [7:0]         pend_r,  pend_nxt;

  logic                 out_valid_r;
  logic [7:0]           out_char_r;
  logic                 out_cv_r;
  logic                 out_last_r;
  logic                 out_tl_r;
  logic                 out_ho_r;
  logic                 out_eod_r;

  logic                 emit_ok;
  logic                 emit;
  logic [7:0]           e_char;
  logic                 e_cv;
  logic                 e_last;
  logic                 e_tl;
  logic                 e_ho;
  logic                 e_eod;

  logic                 ram_we;
  logic                 ram_re;
  logic [WS_CODE_W-1:0] ram_rdata;

  assign emit_ok = !out_valid_r || out_ready;
  assign ram_re  = (state_r == BK_REL_RD);

  lsct_ram #(
    .WIDTH (WS_CODE_W),
    .DEPTH (HOLD_DEPTH)
  ) u_hold_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt_r[HOLD_AW-1:0]),
    .wdata (cmd_head.data[WS_CODE_W-1:0]),
    .re    (ram_re),
    .raddr (idx_r),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    pend_nxt  = pend_r;
    cmd_pop   = 1'b0;
    ram_we    = 1'b0;
    emit      = 1'b0;
    e_char    = 8'd0;
    e_cv      = 1'b0;
    e_last    = 1'b0;
    e_tl      = 1'b0;
    e_ho      = 1'b0;
    e_eod     = 1'b0;

    case (state_r)
      BK_IDLE: begin
        if (!cmd_empty) begin
          case (cmd_head.op)
            CMD_PUSH: begin
              ram_we  = 1'b1;
              cnt_nxt = cnt_r + HOLD_CW'(1);
              cmd_pop = 1'b1;
            end
            CMD_CLEAR: begin
              cnt_nxt = '0;
              cmd_pop = 1'b1;
            end
            CMD_CHAR: begin
              if (cnt_r != '0) begin
                // flush held whitespace first, each entry read from the RAM and then emitted
                pend_nxt  = cmd_head.data;
                idx_nxt   = '0;
                state_nxt = BK_REL_RD;
                cmd_pop   = 1'b1;
              end else if (emit_ok) begin
                emit    = 1'b1;
                e_char  = cmd_head.data;
                e_cv    = 1'b1;
                cmd_pop = 1'b1;
              end
            end
            CMD_CLOSE: begin
              if (emit_ok) begin
                emit    = 1'b1;
                e_last  = 1'b1;
                e_tl    = cmd_head.too_long;
                e_ho    = cmd_head.overflow;
                cnt_nxt = '0;
                cmd_pop = 1'b1;
              end
            end
            CMD_EOD: begin
              if (emit_ok) begin
                emit    = 1'b1;
                e_eod   = 1'b1;
                cmd_pop = 1'b1;
              end
            end
            default: begin
              cmd_pop = 1'b1;
            end
          endcase
        end
      end
      BK_REL_RD: begin
        state_nxt = BK_REL_WR;
      end
      BK_REL_WR: begin
        if (emit_ok) begin
          emit   = 1'b1;
          e_char = ws_char(ram_rdata);
          e_cv   = 1'b1;
          if ((HOLD_CW'(idx_r) + HOLD_CW'(1)) == cnt_r) begin
            state_nxt = BK_CHAR;
          end else begin
            idx_nxt   = idx_r + HOLD_AW'(1);
            state_nxt = BK_REL_RD;
          end
        end
      end
      BK_CHAR: begin
        if (emit_ok) begin
          emit      = 1'b1;
          e_char    = pend_r;
          e_cv      = 1'b1;
          cnt_nxt   = '0;
          state_nxt = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      cnt_r       <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      idx_r   <= idx_nxt;
      pend_r  <= pend_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
        out_char_r  <= e_char;
        out_cv_r    <= e_cv;
        out_last_r  <= e_last;
        out_tl_r    <= e_tl;
        out_ho_r    <= e_ho;
        out_eod_r   <= e_eod;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_char       = out_char_r;
  assign out_char_valid = out_cv_r;
  assign out_line_end   = out_last_r;
  assign out_too_long   = out_tl_r;
  assign out_hold_ovf   = out_ho_r;
  assign out_eod        = out_eod_r;

`ifndef NO_ASSERTIONS
  a_release_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_REL_WR) |-> (HOLD_CW'(idx_r) < cnt_r))
    else $error("release index outside held whitespace");
`endif

endmodule

@@ src/line_splitter_comment_trimmer_unit.sv @@
// Path: a byte's command passes the command queue, then the back end registers the result;
// each held whitespace character released ahead of it passes a RAM read and an emit state.
// Throughput: 1 byte per cycle while the command queue has room; bounded by the back end,
// which drains the held whitespace RAM one entry at a time as the 4-entry queue absorbs input.
// Reset: synchronous, active low; clears line state, queue and output valid, and restores
// preprocess off and a 4096-character line limit. The whitespace RAM needs no clearing.
module line_splitter_comment_trimmer_unit import lsct_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [7:0] data_byte
  input  logic [0:0]            in_tuser,   // [0] end_of_stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [15:0]           out_tdata,  // [7:0] char_out, [8] too_long, [9] hold_overflow
  output logic [1:0]            out_tuser,  // [0] char_valid, [1] end_of_data
  output logic                  out_tlast   // line_end
);

  cmd_t       fr_cmd;
  logic       fr_push;
  logic       q_full;
  cmd_t       q_head;
  logic       q_empty;
  logic       bk_pop;
  logic [7:0] o_char;
  logic       o_cv;
  logic       o_tl;
  logic       o_ho;
  logic       o_eod;

  lsct_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_byte   (in_tdata),
    .in_eos    (in_tuser[0]),
    .cmd_push  (fr_push),
    .cmd_data  (fr_cmd),
    .cmd_full  (q_full)
  );

  lsct_cmd_fifo u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fr_push),
    .push_data (fr_cmd),
    .full      (q_full),
    .pop       (bk_pop),
    .pop_data  (q_head),
    .empty     (q_empty)
  );

  lsct_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd_head       (q_head),
    .cmd_empty      (q_empty),
    .cmd_pop        (bk_pop),
    .out_valid      (out_tvalid),
    .out_ready      (out_tready),
    .out_char       (o_char),
    .out_char_valid (o_cv),
    .out_line_end   (out_tlast),
    .out_too_long   (o_tl),
    .out_hold_ovf   (o_ho),
    .out_eod        (o_eod)
  );

  assign out_tdata = {6'd0, o_ho, o_tl, o_char};
  assign out_tuser = {o_eod, o_cv};

endmodule
